// ===== hdl/bfa_pkg.sv =====
package bfa_pkg;

  localparam int MEM_BYTES_DEF = 256;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_WRITE   = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_BADSTART = 2'd2;

  // extent table read address select
  localparam logic [1:0] RA_CNT   = 2'd0;
  localparam logic [1:0] RA_START = 2'd1;
  localparam logic [1:0] RA_NEXT  = 2'd2;

  // extent table write select
  localparam logic [2:0] WA_CLR       = 3'd0;
  localparam logic [2:0] WA_BEST      = 3'd1;
  localparam logic [2:0] WA_REST      = 3'd2;
  localparam logic [2:0] WA_NEXT      = 3'd3;
  localparam logic [2:0] WA_PREV      = 3'd4;
  localparam logic [2:0] WA_SELF_FREE = 3'd5;
  localparam logic [2:0] WA_SELF_CLR  = 3'd6;

  // result value select
  localparam logic [1:0] RV_ZERO = 2'd0;
  localparam logic [1:0] RV_BEST = 2'd1;
  localparam logic [1:0] RV_DATA = 2'd2;

  typedef struct packed {
    logic       ld_req;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       cnt_ld_prev;
    logic       cnt_dec;
    logic       ext_rd;
    logic [1:0] ext_ra;
    logic       ext_wr;
    logic [2:0] ext_wa;
    logic       data_wr;
    logic       data_clr;
    logic       data_rd;
    logic       scan_eval;
    logic       cap_self;
    logic       merge_next;
    logic       cap_prev;
    logic       res_set;
    logic [1:0] res_code;
    logic [1:0] res_vsel;
    logic       out_load;
  } bfa_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       size_zero;
    logic       start_in;
    logic       start_zero;
    logic       cnt_last;
    logic       rd_vld;
    logic       rd_idx_last;
    logic       e_head;
    logic       e_used;
    logic       next_in;
    logic       found;
    logic       left_nz;
    logic       prev_used;
    logic       out_free;
  } bfa_sts_t;

endpackage

// ===== hdl/bfa_ram.sv =====
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bfa_ctrl.sv =====
module bfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bfa_pkg::bfa_sts_t sts,
  output bfa_pkg::bfa_cmd_t cmd
);
  import bfa_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_ASCAN  = 4'd3;
  localparam logic [3:0] S_AFIN   = 4'd4;
  localparam logic [3:0] S_AREST  = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_RNEXT  = 4'd7;
  localparam logic [3:0] S_RPSCAN = 4'd8;
  localparam logic [3:0] S_RFIN   = 4'd9;
  localparam logic [3:0] S_RFIN2  = 4'd10;
  localparam logic [3:0] S_DRD    = 4'd11;
  localparam logic [3:0] S_RESP   = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.ext_wr   = 1'b1;
        cmd.ext_wa   = WA_CLR;
        cmd.data_wr  = 1'b1;
        cmd.data_clr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_req = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.cmd == CMD_ALLOC) begin
          if (sts.size_zero) begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_NOFIT;
            state_nxt    = S_RESP;
          end else begin
            state_nxt = S_ASCAN;
          end
        end else if (!sts.start_in) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_BADSTART;
          state_nxt    = S_RESP;
        end else begin
          cmd.ext_rd = 1'b1;
          cmd.ext_ra = RA_START;
          state_nxt  = S_CHK;
        end
      end
      S_ASCAN: begin
        cmd.ext_rd    = 1'b1;
        cmd.ext_ra    = RA_CNT;
        cmd.cnt_inc   = 1'b1;
        cmd.scan_eval = 1'b1;
        if (sts.rd_vld && sts.rd_idx_last) state_nxt = S_AFIN;
      end
      S_AFIN: begin
        if (!sts.found) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NOFIT;
          state_nxt    = S_RESP;
        end else begin
          cmd.ext_wr = 1'b1;
          cmd.ext_wa = WA_BEST;
          if (sts.left_nz) begin
            state_nxt = S_AREST;
          end else begin
            cmd.res_set  = 1'b1;
            cmd.res_code = ST_OK;
            cmd.res_vsel = RV_BEST;
            state_nxt    = S_RESP;
          end
        end
      end
      S_AREST: begin
        cmd.ext_wr   = 1'b1;
        cmd.ext_wa   = WA_REST;
        cmd.res_set  = 1'b1;
        cmd.res_code = ST_OK;
        cmd.res_vsel = RV_BEST;
        state_nxt    = S_RESP;
      end
      S_CHK: begin
        if (!sts.e_head || !sts.e_used
            || (sts.cmd == CMD_RELEASE && sts.start_zero)) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_BADSTART;
          state_nxt    = S_RESP;
        end else if (sts.cmd == CMD_RELEASE) begin
          cmd.cap_self = 1'b1;
          if (sts.next_in) begin
            cmd.ext_rd = 1'b1;
            cmd.ext_ra = RA_NEXT;
            state_nxt  = S_RNEXT;
          end else begin
            cmd.cnt_ld_prev = 1'b1;
            state_nxt       = S_RPSCAN;
          end
        end else if (sts.cmd == CMD_WRITE) begin
          cmd.data_wr  = 1'b1;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
          state_nxt    = S_RESP;
        end else begin
          cmd.data_rd = 1'b1;
          state_nxt   = S_DRD;
        end
      end
      S_RNEXT: begin
        if (sts.e_head && !sts.e_used) begin
          cmd.merge_next = 1'b1;
          cmd.ext_wr     = 1'b1;
          cmd.ext_wa     = WA_NEXT;
        end
        cmd.cnt_ld_prev = 1'b1;
        state_nxt       = S_RPSCAN;
      end
      S_RPSCAN: begin
        // walk down to the extent just below the released one
        cmd.ext_rd  = 1'b1;
        cmd.ext_ra  = RA_CNT;
        cmd.cnt_dec = 1'b1;
        if (sts.rd_vld && sts.e_head) begin
          cmd.cap_prev = 1'b1;
          state_nxt    = S_RFIN;
        end
      end
      S_RFIN: begin
        cmd.ext_wr = 1'b1;
        if (!sts.prev_used) begin
          cmd.ext_wa = WA_PREV;
          state_nxt  = S_RFIN2;
        end else begin
          cmd.ext_wa   = WA_SELF_FREE;
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
          state_nxt    = S_RESP;
        end
      end
      S_RFIN2: begin
        cmd.ext_wr   = 1'b1;
        cmd.ext_wa   = WA_SELF_CLR;
        cmd.res_set  = 1'b1;
        cmd.res_code = ST_OK;
        state_nxt    = S_RESP;
      end
      S_DRD: begin
        cmd.res_set  = 1'b1;
        cmd.res_code = ST_OK;
        cmd.res_vsel = RV_DATA;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ===== hdl/bfa_dp.sv =====
module bfa_dp #(
  parameter int MEM_BYTES = bfa_pkg::MEM_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bfa_pkg::bfa_cmd_t cmd,
  output bfa_pkg::bfa_sts_t sts,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_block_start,
  input  logic [7:0]        in_offset,
  input  logic [7:0]        in_request_size,
  input  logic [7:0]        in_write_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [7:0]        out_result_value
);
  import bfa_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);
  localparam int EW = AW + 2;
  localparam int WW = ((AW > 8) ? AW : 8) + 2;

  logic [1:0]    cmd_r;
  logic [7:0]    start_r, off_r, size_r, wdata_r;
  logic [AW-1:0] cnt_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic          found_r;
  logic [AW-1:0] best_r, best_left_r, best_len_r;
  logic [AW-1:0] len_s_r, next_r;
  logic [AW-1:0] prev_r, prev_len_r;
  logic          prev_used_r;
  logic [1:0]    res_code_r;
  logic [7:0]    res_val_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_value_r;

  logic [WW-1:0] start_w, off_w, size_w, sum_w, len_w, next_w, diff_w, rest_w, best_w;
  logic [AW-1:0] start_idx, addr, left, ext_raddr, ext_waddr;
  logic [EW-1:0] ext_wdata, ext_rdata, clr_val;
  logic [7:0]    data_rdata, data_wdata;
  logic [AW-1:0] data_waddr;
  logic          e_head, e_used, cand;
  logic [AW-1:0] e_len;

  assign start_w   = WW'(start_r);
  assign off_w     = WW'(off_r);
  assign size_w    = WW'(size_r);
  assign sum_w     = start_w + off_w;
  assign start_idx = start_w[AW-1:0];
  assign addr      = sum_w[AW-1:0];

  assign e_head = ext_rdata[AW+1];
  assign e_used = ext_rdata[AW];
  assign e_len  = ext_rdata[AW-1:0];
  assign len_w  = WW'(e_len);
  assign next_w = start_w + len_w;
  assign diff_w = len_w - size_w;
  assign left   = diff_w[AW-1:0];
  assign cand   = e_head && !e_used && (len_w >= size_w);
  assign rest_w = WW'(best_r) + size_w;
  assign best_w = WW'(best_r);

  always_comb begin
    if (cnt_r == AW'(0)) begin
      clr_val = {2'b11, AW'(1)};
    end else if (cnt_r == AW'(1)) begin
      clr_val = {2'b10, AW'(MEM_BYTES - 1)};
    end else begin
      clr_val = '0;
    end
  end

  always_comb begin
    unique case (cmd.ext_ra)
      RA_START: ext_raddr = start_idx;
      RA_NEXT:  ext_raddr = next_w[AW-1:0];
      default:  ext_raddr = cnt_r;
    endcase
  end

  always_comb begin
    unique case (cmd.ext_wa)
      WA_BEST: begin
        ext_waddr = best_r;
        ext_wdata = {2'b11, (best_left_r != '0) ? size_w[AW-1:0] : best_len_r};
      end
      WA_REST: begin
        ext_waddr = rest_w[AW-1:0];
        ext_wdata = {2'b10, best_left_r};
      end
      WA_NEXT: begin
        ext_waddr = next_r;
        ext_wdata = '0;
      end
      WA_PREV: begin
        ext_waddr = prev_r;
        ext_wdata = {2'b10, prev_len_r + len_s_r};
      end
      WA_SELF_FREE: begin
        ext_waddr = start_idx;
        ext_wdata = {2'b10, len_s_r};
      end
      WA_SELF_CLR: begin
        ext_waddr = start_idx;
        ext_wdata = '0;
      end
      default: begin
        ext_waddr = cnt_r;
        ext_wdata = clr_val;
      end
    endcase
  end

  assign data_waddr = cmd.data_clr ? cnt_r : addr;
  assign data_wdata = cmd.data_clr ? 8'd0 : wdata_r;

  bfa_ram #(.WIDTH(EW), .DEPTH(MEM_BYTES)) u_ext_ram (
    .clk   (clk),
    .we    (cmd.ext_wr),
    .waddr (ext_waddr),
    .wdata (ext_wdata),
    .re    (cmd.ext_rd),
    .raddr (ext_raddr),
    .rdata (ext_rdata)
  );

  bfa_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_data_ram (
    .clk   (clk),
    .we    (cmd.data_wr),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .re    (cmd.data_rd),
    .raddr (addr),
    .rdata (data_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + AW'(1);
      end else if (cmd.cnt_ld_prev) begin
        cnt_r <= start_idx - AW'(1);
      end else if (cmd.cnt_dec) begin
        cnt_r <= cnt_r - AW'(1);
      end
      rd_vld_r <= cmd.ext_rd;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= ext_raddr;
    if (cmd.ld_req) begin
      cmd_r   <= in_command;
      start_r <= in_block_start;
      off_r   <= in_offset;
      size_r  <= in_request_size;
      wdata_r <= in_write_data;
      found_r <= 1'b0;
    end else if (cmd.scan_eval && rd_vld_r && cand && (!found_r || left < best_left_r)) begin
      found_r     <= 1'b1;
      best_r      <= rd_idx_r;
      best_left_r <= left;
      best_len_r  <= e_len;
    end
    if (cmd.cap_self) begin
      len_s_r <= e_len;
      next_r  <= next_w[AW-1:0];
    end else if (cmd.merge_next) begin
      len_s_r <= len_s_r + e_len;
    end
    if (cmd.cap_prev) begin
      prev_r      <= rd_idx_r;
      prev_used_r <= e_used;
      prev_len_r  <= e_len;
    end
    if (cmd.res_set) begin
      res_code_r <= cmd.res_code;
      unique case (cmd.res_vsel)
        RV_BEST: res_val_r <= best_w[7:0];
        RV_DATA: res_val_r <= data_rdata;
        default: res_val_r <= 8'd0;
      endcase
    end
    if (cmd.out_load) begin
      out_status_r <= res_code_r;
      out_value_r  <= res_val_r;
    end
  end

  always_comb begin
    sts.cmd         = cmd_r;
    sts.size_zero   = (size_r == 8'd0);
    sts.start_in    = start_w < WW'(MEM_BYTES);
    sts.start_zero  = (start_r == 8'd0);
    sts.cnt_last    = (cnt_r == AW'(MEM_BYTES - 1));
    sts.rd_vld      = rd_vld_r;
    sts.rd_idx_last = (rd_idx_r == AW'(MEM_BYTES - 1));
    sts.e_head      = e_head;
    sts.e_used      = e_used;
    sts.next_in     = next_w < WW'(MEM_BYTES);
    sts.found       = found_r;
    sts.left_nz     = (best_left_r != '0);
    sts.prev_used   = prev_used_r;
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;

endmodule

// ===== hdl/best_fit_byte_allocator_unit.sv =====
// Allocate: the best-fit scan reads the extent table one entry per cycle over all MEM_BYTES;
// a zero-size allocate is answered without a scan.
// Release: walks the extent table down one entry at a time to the preceding extent head.
// Write and read check the extent first; a read then reads the data memory.
// One request at a time: a new request is taken only once the last result is loaded. A waiting result
// stalls input only when the next result is also ready. Reset: synchronous; a clearing
// pass over all MEM_BYTES entries follows, in_ready low.
module best_fit_byte_allocator_unit #(
  parameter int MEM_BYTES = bfa_pkg::MEM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_block_start,
  input  logic [7:0] in_offset,
  input  logic [7:0] in_request_size,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_result_value
);
  import bfa_pkg::*;

  bfa_cmd_t cmd;
  bfa_sts_t sts;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfa_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_command),
    .in_block_start   (in_block_start),
    .in_offset        (in_offset),
    .in_request_size  (in_request_size),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_result_value (out_result_value)
  );

endmodule

// ===== bench/tb.sv =====
module tb;
  import bfa_pkg::*;

  localparam int NBYTES = 256;
  localparam int STALL_LIMIT = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_command = CMD_ALLOC;
  logic [7:0] in_block_start = '0;
  logic [7:0] in_offset = '0;
  logic [7:0] in_request_size = 8'd1;
  logic [7:0] in_write_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_result_value;

  best_fit_byte_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_block_start(in_block_start),
    .in_offset(in_offset), .in_request_size(in_request_size),
    .in_write_data(in_write_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_result_value(out_result_value)
  );

  always #2 clk = ~clk;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] value;
  } alloc_result_t;

  // shadow allocator state
  logic [7:0] mem_byte [NBYTES];
  logic       ext_head [NBYTES];
  logic       ext_used [NBYTES];
  int         ext_len  [NBYTES];
  alloc_result_t pending_results[$];
  int         live_blocks[$];
  int         errors = 0;
  int         sent = 0;
  int         checked = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  bit         done = 1'b0;
  int         cnt_nofit = 0, cnt_bad = 0, cnt_ok = 0;

  function automatic bit used_start(int s);
    return ext_head[s] && ext_used[s];
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] cmd, logic [7:0] start,
                                                    logic [7:0] off, logic [7:0] size,
                                                    logic [7:0] wdata);
    alloc_result_t r;
    int best, best_left, left, rest, nxt, prv, addr;
    bit found;
    r.status = ST_OK;
    r.value = '0;
    addr = (int'(start) + int'(off)) % NBYTES;
    case (cmd)
      CMD_ALLOC: begin
        found = 1'b0;
        best = 0;
        best_left = 0;
        if (size == 0) begin
          r.status = ST_NOFIT;
          return r;
        end
        for (int p = 0; p < NBYTES; p++) begin
          if (ext_head[p] && !ext_used[p] && ext_len[p] >= size) begin
            left = ext_len[p] - size;
            if (!found || left < best_left) begin
              found = 1'b1;
              best = p;
              best_left = left;
            end
          end
        end
        if (!found) begin
          r.status = ST_NOFIT;
          return r;
        end
        ext_used[best] = 1'b1;
        if (best_left != 0) begin
          rest = best + size;
          ext_len[best] = size;
          ext_head[rest] = 1'b1;
          ext_used[rest] = 1'b0;
          ext_len[rest] = best_left;
        end
        r.value = best[7:0];
        live_blocks.push_back(best);
      end
      CMD_RELEASE: begin
        if (start == 0 || !used_start(start)) begin
          r.status = ST_BADSTART;
          return r;
        end
        ext_used[start] = 1'b0;
        nxt = start + ext_len[start];
        if (nxt < NBYTES && ext_head[nxt] && !ext_used[nxt]) begin
          ext_len[start] += ext_len[nxt];
          ext_head[nxt] = 1'b0;
          ext_len[nxt] = 0;
        end
        prv = start - 1;
        while (!ext_head[prv]) prv--;
        if (!ext_used[prv]) begin
          ext_len[prv] += ext_len[start];
          ext_head[start] = 1'b0;
          ext_len[start] = 0;
        end
        foreach (live_blocks[i])
          if (live_blocks[i] == start) begin
            live_blocks.delete(i);
            break;
          end
      end
      CMD_WRITE: begin
        if (used_start(start)) mem_byte[addr] = wdata;
        else r.status = ST_BADSTART;
      end
      default: begin
        if (used_start(start)) r.value = mem_byte[addr];
        else r.status = ST_BADSTART;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch #%0d: %s got %0d expected %0d", checked, what, got, want);
    errors++;
  endtask

  // sender: bursts with random gaps; valid stays high across a burst
  task automatic send_request(logic [1:0] cmd, logic [7:0] start, logic [7:0] off,
                              logic [7:0] size, logic [7:0] wdata);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_block_start <= start;
    in_offset <= off;
    in_request_size <= size;
    in_write_data <= wdata;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_request(cmd, start, off, size, wdata));
    sent++;
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_block();
    if (live_blocks.size() == 0 || $urandom_range(0, 9) == 0)
      return 8'($urandom_range(0, 255));
    return 8'(live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
  endfunction

  // receiver stall pattern: phases of always-ready and random stalls
  always @(negedge clk) begin
    if (((sent / 64) % 3) == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_result_value !== want.value)
          report_mismatch("result_value", out_result_value, want.value);
        case (want.status)
          ST_OK: cnt_ok++;
          ST_NOFIT: cnt_nofit++;
          default: cnt_bad++;
        endcase
      end
      checked++;
    end
  end

  // watchdog on accept activity
  always @(posedge clk) begin
    if (!rst_n || done || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("best_fit_byte_allocator_unit regression: fail");
      $finish;
    end
  end

  task automatic test_directed();
    // zero request and full-size request
    send_request(CMD_ALLOC, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(CMD_ALLOC, 8'd0, 8'd0, 8'd255, 8'd0);
    // exact fit of whole store, then no fit
    send_request(CMD_ALLOC, 8'd0, 8'd0, 8'd1, 8'd0);
    send_request(CMD_RELEASE, 8'd1, 8'd0, 8'd0, 8'd0);
    send_request(CMD_ALLOC, 8'd0, 8'd0, 8'd255, 8'd0);
    send_request(CMD_ALLOC, 8'd0, 8'd0, 8'd1, 8'd0);
    send_request(CMD_RELEASE, 8'd1, 8'd0, 8'd0, 8'd0);
    // reserved byte: release rejected, access accepted
    send_request(CMD_RELEASE, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(CMD_WRITE, 8'd0, 8'd0, 8'd0, 8'hA5);
    send_request(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0);
    // split and best fit hole
    send_request(CMD_ALLOC, 8'd0, 8'd0, 8'd10, 8'd0);
    send_request(CMD_ALLOC, 8'd0, 8'd0, 8'd5, 8'd0);
    send_request(CMD_ALLOC, 8'd0, 8'd0, 8'd20, 8'd0);
    send_request(CMD_RELEASE, 8'd1, 8'd0, 8'd0, 8'd0);
    send_request(CMD_ALLOC, 8'd0, 8'd0, 8'd10, 8'd0);
    send_request(CMD_RELEASE, 8'd11, 8'd0, 8'd0, 8'd0);
    // offset wrap and max fields
    send_request(CMD_WRITE, 8'd16, 8'd255, 8'd255, 8'hFF);
    send_request(CMD_READ, 8'd16, 8'd255, 8'd0, 8'd0);
    send_request(CMD_READ, 8'd0, 8'd15, 8'd0, 8'd0);
    // unknown start, then releases that coalesce with free neighbours
    send_request(CMD_WRITE, 8'd255, 8'd0, 8'd0, 8'h5A);
    send_request(CMD_READ, 8'd3, 8'd0, 8'd0, 8'd0);
    send_request(CMD_RELEASE, 8'd255, 8'd0, 8'd0, 8'd0);
    send_request(CMD_RELEASE, 8'd1, 8'd0, 8'd0, 8'd0);
    send_request(CMD_RELEASE, 8'd16, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_random_traffic(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30)
        send_request(CMD_ALLOC, 8'($urandom), 8'($urandom),
                     ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(1, 24)),
                     8'($urandom));
      else if (sel < 55)
        send_request(CMD_RELEASE, pick_block(), 8'($urandom), 8'($urandom), 8'($urandom));
      else if (sel < 78)
        send_request(CMD_WRITE, pick_block(), 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_request(CMD_READ, pick_block(), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NBYTES; i++) begin
      mem_byte[i] = '0;
      ext_head[i] = 1'b0;
      ext_used[i] = 1'b0;
      ext_len[i] = 0;
    end
    ext_head[0] = 1'b1; ext_used[0] = 1'b1; ext_len[0] = 1;
    ext_head[1] = 1'b1; ext_len[1] = NBYTES - 1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(500);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    done = 1'b1;
    $display("covered %0d requests: %0d ok, %0d no-fit, %0d bad-start",
             sent, cnt_ok, cnt_nofit, cnt_bad);
    if (errors == 0) $display("best_fit_byte_allocator_unit regression: pass");
    else $display("best_fit_byte_allocator_unit regression: fail");
    $finish;
  end

endmodule
